/* rtl/i2cseq_pkg.sv */
// Package for the I2C register transaction sequencer.
// Holds the codes, status constants and item/result structs. No dependencies.
package i2cseq_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EVENT = 2'd2
  } cmd_t;

  // Actions handed to the byte-level bus engine
  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_RD_ACK  = 3'd2,
    ACT_RD_NACK = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_NONE    = 3'd5
  } action_t;

  // Transaction phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_SLA_W  = 4'd2,
    PH_REG    = 4'd3,
    PH_WDATA  = 4'd4,
    PH_RSTART = 4'd5,
    PH_SLA_R  = 4'd6,
    PH_RDATA  = 4'd7,
    PH_STOP   = 4'd8
  } phase_t;

  // Expected engine status codes (low three bits masked)
  localparam logic [7:0] STATUS_MASK     = 8'hF8;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] ST_RSTART       = 8'h10;
  localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
  localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic [7:0] read_count;
    logic [7:0] bus_status;
    logic [7:0] bus_data;
  } item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] bus_byte;
    logic [7:0] read_value;
    logic       read_valid;
    logic       last_byte;
    logic       done_res;
    logic       success;
  } result_t;

endpackage

/* rtl/i2cseq_fsm.sv */
// Transaction state machine: phase and saved request state, plus the
// per-item result logic. Depends on i2cseq_pkg.
module i2cseq_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  i2cseq_pkg::item_t   item,
  output i2cseq_pkg::result_t res
);

  i2cseq_pkg::phase_t phase, phase_next;
  logic       is_read, is_read_next;
  logic [6:0] saved_device, saved_device_next;
  logic [7:0] saved_register, saved_register_next;
  logic [7:0] saved_value, saved_value_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic       pending_success, pending_success_next;

  logic [7:0] st;
  logic       busy;
  logic       bad_request;
  logic       many_left;

  assign st          = item.bus_status & i2cseq_pkg::STATUS_MASK;
  assign busy        = (phase != i2cseq_pkg::PH_IDLE);
  assign bad_request = busy || ((item.command == i2cseq_pkg::CMD_READ) &&
                                (item.read_count == 8'd0));
  assign many_left   = (bytes_left > 8'd1);

  // Next-state logic
  always_comb begin
    phase_next           = phase;
    is_read_next         = is_read;
    saved_device_next    = saved_device;
    saved_register_next  = saved_register;
    saved_value_next     = saved_value;
    bytes_left_next      = bytes_left;
    pending_success_next = pending_success;
    case (item.command)
      i2cseq_pkg::CMD_WRITE, i2cseq_pkg::CMD_READ: begin
        if (!bad_request) begin
          is_read_next         = item.command[0];
          saved_device_next    = item.device_address;
          saved_register_next  = item.register_address;
          saved_value_next     = item.write_value;
          bytes_left_next      = item.command[0] ? item.read_count : 8'd0;
          pending_success_next = 1'b0;
          phase_next           = i2cseq_pkg::PH_START;
        end
      end
      i2cseq_pkg::CMD_EVENT: begin
        case (phase)
          i2cseq_pkg::PH_START: begin
            if (st == i2cseq_pkg::ST_START) begin
              phase_next = i2cseq_pkg::PH_SLA_W;
            end else begin
              phase_next = i2cseq_pkg::PH_STOP;
              pending_success_next = 1'b0;
            end
          end
          i2cseq_pkg::PH_SLA_W: begin
            if (st == i2cseq_pkg::ST_SLA_W_ACK) begin
              phase_next = i2cseq_pkg::PH_REG;
            end else begin
              phase_next = i2cseq_pkg::PH_STOP;
              pending_success_next = 1'b0;
            end
          end
          i2cseq_pkg::PH_REG: begin
            if (st != i2cseq_pkg::ST_DATA_TX_ACK) begin
              phase_next = i2cseq_pkg::PH_STOP;
              pending_success_next = 1'b0;
            end else if (is_read) begin
              phase_next = i2cseq_pkg::PH_RSTART;
            end else begin
              phase_next = i2cseq_pkg::PH_WDATA;
            end
          end
          i2cseq_pkg::PH_WDATA: begin
            phase_next = i2cseq_pkg::PH_STOP;
            pending_success_next = (st == i2cseq_pkg::ST_DATA_TX_ACK);
          end
          i2cseq_pkg::PH_RSTART: begin
            if (st == i2cseq_pkg::ST_RSTART) begin
              phase_next = i2cseq_pkg::PH_SLA_R;
            end else begin
              phase_next = i2cseq_pkg::PH_STOP;
              pending_success_next = 1'b0;
            end
          end
          i2cseq_pkg::PH_SLA_R: begin
            if (st == i2cseq_pkg::ST_SLA_R_ACK) begin
              phase_next = i2cseq_pkg::PH_RDATA;
            end else begin
              phase_next = i2cseq_pkg::PH_STOP;
              pending_success_next = 1'b0;
            end
          end
          i2cseq_pkg::PH_RDATA: begin
            if (many_left) begin
              if (st == i2cseq_pkg::ST_DATA_RX_ACK) begin
                bytes_left_next = bytes_left - 8'd1;
              end else begin
                phase_next = i2cseq_pkg::PH_STOP;
                pending_success_next = 1'b0;
              end
            end else begin
              phase_next = i2cseq_pkg::PH_STOP;
              if (st == i2cseq_pkg::ST_DATA_RX_NACK) begin
                bytes_left_next      = 8'd0;
                pending_success_next = 1'b1;
              end else begin
                pending_success_next = 1'b0;
              end
            end
          end
          i2cseq_pkg::PH_STOP: begin
            pending_success_next = 1'b0;
            phase_next           = i2cseq_pkg::PH_IDLE;
          end
          default: begin
            // idle: events are ignored
          end
        endcase
      end
      default: begin
        // unused command code: ignored
      end
    endcase
  end

  // Result logic
  always_comb begin
    res = '{action: i2cseq_pkg::ACT_NONE, bus_byte: 8'd0, read_value: 8'd0,
            read_valid: 1'b0, last_byte: 1'b0, done_res: 1'b0, success: 1'b0};
    case (item.command)
      i2cseq_pkg::CMD_WRITE, i2cseq_pkg::CMD_READ: begin
        if (bad_request) begin
          res.done_res = 1'b1;
        end else begin
          res.action = i2cseq_pkg::ACT_START;
        end
      end
      i2cseq_pkg::CMD_EVENT: begin
        case (phase)
          i2cseq_pkg::PH_START: begin
            if (st == i2cseq_pkg::ST_START) begin
              res.action   = i2cseq_pkg::ACT_SEND;
              res.bus_byte = {saved_device, 1'b0};
            end else begin
              res.action = i2cseq_pkg::ACT_STOP;
            end
          end
          i2cseq_pkg::PH_SLA_W: begin
            if (st == i2cseq_pkg::ST_SLA_W_ACK) begin
              res.action   = i2cseq_pkg::ACT_SEND;
              res.bus_byte = saved_register;
            end else begin
              res.action = i2cseq_pkg::ACT_STOP;
            end
          end
          i2cseq_pkg::PH_REG: begin
            if (st != i2cseq_pkg::ST_DATA_TX_ACK) begin
              res.action = i2cseq_pkg::ACT_STOP;
            end else if (is_read) begin
              res.action = i2cseq_pkg::ACT_START;
            end else begin
              res.action   = i2cseq_pkg::ACT_SEND;
              res.bus_byte = saved_value;
            end
          end
          i2cseq_pkg::PH_WDATA: begin
            res.action = i2cseq_pkg::ACT_STOP;
          end
          i2cseq_pkg::PH_RSTART: begin
            if (st == i2cseq_pkg::ST_RSTART) begin
              res.action   = i2cseq_pkg::ACT_SEND;
              res.bus_byte = {saved_device, 1'b1};
            end else begin
              res.action = i2cseq_pkg::ACT_STOP;
            end
          end
          i2cseq_pkg::PH_SLA_R: begin
            if (st == i2cseq_pkg::ST_SLA_R_ACK) begin
              res.action = many_left ? i2cseq_pkg::ACT_RD_ACK
                                     : i2cseq_pkg::ACT_RD_NACK;
            end else begin
              res.action = i2cseq_pkg::ACT_STOP;
            end
          end
          i2cseq_pkg::PH_RDATA: begin
            if (many_left) begin
              if (st == i2cseq_pkg::ST_DATA_RX_ACK) begin
                res.read_value = item.bus_data;
                res.read_valid = 1'b1;
                // ack again unless only one byte remains after this one
                res.action = (bytes_left > 8'd2) ? i2cseq_pkg::ACT_RD_ACK
                                                 : i2cseq_pkg::ACT_RD_NACK;
              end else begin
                res.action = i2cseq_pkg::ACT_STOP;
              end
            end else begin
              res.action = i2cseq_pkg::ACT_STOP;
              if (st == i2cseq_pkg::ST_DATA_RX_NACK) begin
                res.read_value = item.bus_data;
                res.read_valid = 1'b1;
                res.last_byte  = 1'b1;
              end
            end
          end
          i2cseq_pkg::PH_STOP: begin
            res.done_res = 1'b1;
            res.success  = pending_success;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cseq_pkg::PH_IDLE;
      is_read         <= 1'b0;
      saved_device    <= 7'd0;
      saved_register  <= 8'd0;
      saved_value     <= 8'd0;
      bytes_left      <= 8'd0;
      pending_success <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      is_read         <= is_read_next;
      saved_device    <= saved_device_next;
      saved_register  <= saved_register_next;
      saved_value     <= saved_value_next;
      bytes_left      <= bytes_left_next;
      pending_success <= pending_success_next;
    end
  end

endmodule

/* rtl/i2c_register_transaction_sequencer_top.sv */
// I2C register transaction sequencer, top level.
// Input register, state machine (i2cseq_fsm) and result register.
// Depends on i2cseq_pkg and i2cseq_fsm.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per handshake:
//   a write request, a read request, or a bus engine status event.
//   Output channel (out_valid / out_stall) returns exactly one result item
//   per input item, in order: the next engine action, a send byte, any
//   received byte, and done/success when a transaction ends.
//   An accepted item waits in the input register, is processed by the state
//   machine and is loaded into the result register, which drives out_valid.
//   Throughput: one item per cycle while the output is not stalled; the phase
//   update for an item is a single compare-and-select step between the two
//   registers, so the next item sees the updated state immediately.
//   Stalls: while out_stall holds a result, the result register keeps it
//   and one more item may sit in the input register; in_stall rises only
//   when both are occupied and the output cannot move.
//   Reset (rst, synchronous): both registers empty, phase idle, saved
//   request state and pending success cleared.
module i2c_register_transaction_sequencer_top (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [6:0] device_address,
  input  logic [7:0] register_address,
  input  logic [7:0] write_value,
  input  logic [7:0] read_count,
  input  logic [7:0] bus_status,
  input  logic [7:0] bus_data,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] bus_action,
  output logic [7:0] bus_byte,
  output logic [7:0] read_value,
  output logic       read_valid,
  output logic       last_byte,
  output logic       done_res,
  output logic       success
);

  i2cseq_pkg::item_t   item_reg;
  logic                item_full;
  i2cseq_pkg::result_t res_next;
  i2cseq_pkg::result_t res_reg;
  logic                res_full;

  logic advance;  // result register can take a new result
  logic fire;     // held item is processed this cycle
  logic in_take;

  assign advance  = !res_full || !out_stall;
  assign fire     = item_full && advance;
  assign in_stall = item_full && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_take) begin
      item_full <= 1'b1;
    end else if (fire) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_reg <= '{command: command, device_address: device_address,
                    register_address: register_address,
                    write_value: write_value, read_count: read_count,
                    bus_status: bus_status, bus_data: bus_data};
    end
  end

  i2cseq_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item_reg),
    .res  (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (fire) begin
      res_full <= 1'b1;
    end else if (!out_stall) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_reg <= res_next;
    end
  end

  assign out_valid  = res_full;
  assign bus_action = res_reg.action;
  assign bus_byte   = res_reg.bus_byte;
  assign read_value = res_reg.read_value;
  assign read_valid = res_reg.read_valid;
  assign last_byte  = res_reg.last_byte;
  assign done_res   = res_reg.done_res;
  assign success    = res_reg.success;

endmodule

/* test/i2c_txn_checker.sv */
`timescale 1ns / 1ps
// Result checker for the I2C register transaction sequencer: it follows both
// channels, works out each expected result, and compares results in order.
// Depends on i2cseq_pkg.
module i2c_txn_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] command,
  input  logic [6:0] device_address,
  input  logic [7:0] register_address,
  input  logic [7:0] write_value,
  input  logic [7:0] read_count,
  input  logic [7:0] bus_status,
  input  logic [7:0] bus_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] bus_action,
  input  logic [7:0] bus_byte,
  input  logic [7:0] read_value,
  input  logic       read_valid,
  input  logic       last_byte,
  input  logic       done_res,
  input  logic       success,
  output int         mismatch_count,
  output int         results_outstanding
);

  // sequencing state as the block should hold it
  i2cseq_pkg::phase_t txn_phase;
  logic               txn_is_read;
  logic [6:0]         txn_device;
  logic [7:0]         txn_register;
  logic [7:0]         txn_value;
  logic [7:0]         bytes_remaining;
  logic               stop_success;

  i2cseq_pkg::result_t expected_responses[$];

  function automatic i2cseq_pkg::action_t enter_stop(input logic ok);
    stop_success = ok;
    txn_phase    = i2cseq_pkg::PH_STOP;
    return i2cseq_pkg::ACT_STOP;
  endfunction

  function automatic i2cseq_pkg::result_t predict_engine_response(
    input logic [1:0] cmd,
    input logic [6:0] dev,
    input logic [7:0] regaddr,
    input logic [7:0] value,
    input logic [7:0] count,
    input logic [7:0] status_raw,
    input logic [7:0] rx
  );
    i2cseq_pkg::result_t r;
    logic [7:0]          status;
    logic                busy;
    r        = '0;
    r.action = i2cseq_pkg::ACT_NONE;
    status   = status_raw & i2cseq_pkg::STATUS_MASK;
    busy     = (txn_phase != i2cseq_pkg::PH_IDLE);
    if (cmd == i2cseq_pkg::CMD_WRITE || cmd == i2cseq_pkg::CMD_READ) begin
      if (busy || (cmd == i2cseq_pkg::CMD_READ && count == 8'd0)) begin
        r.done_res = 1'b1;
      end else begin
        txn_is_read     = (cmd == i2cseq_pkg::CMD_READ);
        txn_device      = dev;
        txn_register    = regaddr;
        txn_value       = value;
        bytes_remaining = (cmd == i2cseq_pkg::CMD_READ) ? count : 8'd0;
        stop_success    = 1'b0;
        txn_phase       = i2cseq_pkg::PH_START;
        r.action        = i2cseq_pkg::ACT_START;
      end
    end else if (cmd == i2cseq_pkg::CMD_EVENT && busy) begin
      case (txn_phase)
        i2cseq_pkg::PH_START: begin
          if (status == i2cseq_pkg::ST_START) begin
            r.action   = i2cseq_pkg::ACT_SEND;
            r.bus_byte = {txn_device, 1'b0};
            txn_phase  = i2cseq_pkg::PH_SLA_W;
          end else r.action = enter_stop(1'b0);
        end
        i2cseq_pkg::PH_SLA_W: begin
          if (status == i2cseq_pkg::ST_SLA_W_ACK) begin
            r.action   = i2cseq_pkg::ACT_SEND;
            r.bus_byte = txn_register;
            txn_phase  = i2cseq_pkg::PH_REG;
          end else r.action = enter_stop(1'b0);
        end
        i2cseq_pkg::PH_REG: begin
          if (status != i2cseq_pkg::ST_DATA_TX_ACK) begin
            r.action = enter_stop(1'b0);
          end else if (txn_is_read) begin
            r.action  = i2cseq_pkg::ACT_START;
            txn_phase = i2cseq_pkg::PH_RSTART;
          end else begin
            r.action   = i2cseq_pkg::ACT_SEND;
            r.bus_byte = txn_value;
            txn_phase  = i2cseq_pkg::PH_WDATA;
          end
        end
        i2cseq_pkg::PH_WDATA: r.action = enter_stop(status == i2cseq_pkg::ST_DATA_TX_ACK);
        i2cseq_pkg::PH_RSTART: begin
          if (status == i2cseq_pkg::ST_RSTART) begin
            r.action   = i2cseq_pkg::ACT_SEND;
            r.bus_byte = {txn_device, 1'b1};
            txn_phase  = i2cseq_pkg::PH_SLA_R;
          end else r.action = enter_stop(1'b0);
        end
        i2cseq_pkg::PH_SLA_R: begin
          if (status == i2cseq_pkg::ST_SLA_R_ACK) begin
            r.action  = (bytes_remaining > 8'd1) ? i2cseq_pkg::ACT_RD_ACK
                                                 : i2cseq_pkg::ACT_RD_NACK;
            txn_phase = i2cseq_pkg::PH_RDATA;
          end else r.action = enter_stop(1'b0);
        end
        i2cseq_pkg::PH_RDATA: begin
          if (bytes_remaining > 8'd1) begin
            if (status == i2cseq_pkg::ST_DATA_RX_ACK) begin
              r.read_value    = rx;
              r.read_valid    = 1'b1;
              bytes_remaining = bytes_remaining - 8'd1;
              r.action        = (bytes_remaining > 8'd1) ? i2cseq_pkg::ACT_RD_ACK
                                                         : i2cseq_pkg::ACT_RD_NACK;
            end else r.action = enter_stop(1'b0);
          end else if (status == i2cseq_pkg::ST_DATA_RX_NACK) begin
            r.read_value    = rx;
            r.read_valid    = 1'b1;
            r.last_byte     = 1'b1;
            bytes_remaining = 8'd0;
            r.action        = enter_stop(1'b1);
          end else r.action = enter_stop(1'b0);
        end
        default: begin // stop issued: this event closes the transaction
          r.done_res   = 1'b1;
          r.success    = stop_success;
          stop_success = 1'b0;
          txn_phase    = i2cseq_pkg::PH_IDLE;
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    i2cseq_pkg::result_t want;
    if (rst) begin
      txn_phase       = i2cseq_pkg::PH_IDLE;
      txn_is_read     = 1'b0;
      txn_device      = '0;
      txn_register    = '0;
      txn_value       = '0;
      bytes_remaining = '0;
      stop_success    = 1'b0;
      expected_responses.delete();
      mismatch_count  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          $error("result item arrived with no expected item pending");
          mismatch_count++;
        end else begin
          want = expected_responses.pop_front();
          check_field("bus_action", int'(want.action), int'(bus_action));
          check_field("bus_byte", int'(want.bus_byte), int'(bus_byte));
          check_field("read_value", int'(want.read_value), int'(read_value));
          check_field("read_valid", int'(want.read_valid), int'(read_valid));
          check_field("last_byte", int'(want.last_byte), int'(last_byte));
          check_field("done_res", int'(want.done_res), int'(done_res));
          check_field("success", int'(want.success), int'(success));
        end
      end
      if (in_valid && !in_stall)
        expected_responses.push_back(predict_engine_response(command, device_address,
          register_address, write_value, read_count, bus_status, bus_data));
    end
    results_outstanding = expected_responses.size();
  end

endmodule

/* test/tb_i2c_register_transaction_sequencer_top.sv */
`timescale 1ns / 1ps
// Testbench top for the I2C register transaction sequencer: clock, reset,
// request/event stimulus, output stall pattern and the final verdict.
// Depends on i2cseq_pkg, i2c_txn_checker and the sequencer RTL.
module tb_i2c_register_transaction_sequencer_top;

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // cycle budget for the whole run
  localparam int CYCLE_LIMIT = 200000;
  // receiver hold-off: starts at this cycle; HOLD_CYCLES loads its counter
  localparam int HOLD_START  = 150;
  localparam int HOLD_CYCLES = 80;
  // window with no idling on either side
  localparam int QUIET_FROM  = 350;
  localparam int QUIET_TO    = 500;
  localparam int IDLE_PCT    = 18;
  localparam int TARGET_ITEMS = 400;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] command;
  logic [6:0] device_address;
  logic [7:0] register_address;
  logic [7:0] write_value;
  logic [7:0] read_count;
  logic [7:0] bus_status;
  logic [7:0] bus_data;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] bus_action;
  logic [7:0] bus_byte;
  logic [7:0] read_value;
  logic       read_valid;
  logic       last_byte;
  logic       done_res;
  logic       success;

  int mismatch_count;
  int results_outstanding;
  int cycle_count = 0;
  int hold_left;
  int useful_items = 0;

  always #10 clk = ~clk;

  i2c_register_transaction_sequencer_top i_dut (
    .clk, .rst,
    .in_valid, .in_stall,
    .command, .device_address, .register_address, .write_value,
    .read_count, .bus_status, .bus_data,
    .out_valid, .out_stall,
    .bus_action, .bus_byte, .read_value, .read_valid,
    .last_byte, .done_res, .success
  );

  i2c_txn_checker i_checker (
    .clk, .rst,
    .in_valid, .in_stall,
    .command, .device_address, .register_address, .write_value,
    .read_count, .bus_status, .bus_data,
    .out_valid, .out_stall,
    .bus_action, .bus_byte, .read_value, .read_valid,
    .last_byte, .done_res, .success,
    .mismatch_count, .results_outstanding
  );

  // Timeout guard. Only a hung block gets here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit idle_allowed();
    return !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);
  endfunction

  // Receiver: random stalls, one long hold-off so the input register and
  // result register both fill and in_stall rises, plus a quiet window.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (cycle_count == HOLD_START) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!idle_allowed()) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Every field random; callers override what matters.
  function automatic i2cseq_pkg::item_t random_item(input logic [1:0] cmd);
    i2cseq_pkg::item_t it;
    it.command          = cmd;
    it.device_address   = 7'($urandom_range(0, 127));
    it.register_address = 8'($urandom_range(0, 255));
    it.write_value      = 8'($urandom_range(0, 255));
    it.read_count       = 8'($urandom_range(0, 255));
    it.bus_status       = 8'($urandom_range(0, 255));
    it.bus_data         = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Called right after a rising edge. Optional idle gap, then hold the item
  // until a rising edge sees valid high and stall low. Stall is sampled at
  // the falling edge, where it is settled for the coming rising edge.
  task automatic send_item(input i2cseq_pkg::item_t it, input bit counted);
    bit taken;
    while (idle_allowed() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    command          <= it.command;
    device_address   <= it.device_address;
    register_address <= it.register_address;
    write_value      <= it.write_value;
    read_count       <= it.read_count;
    bus_status       <= it.bus_status;
    bus_data         <= it.bus_data;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (counted) useful_items++;
  endtask

  task automatic send_event(input logic [7:0] status);
    i2cseq_pkg::item_t it;
    it            = random_item(i2cseq_pkg::CMD_EVENT);
    it.bus_status = status;
    send_item(it, 1'b1);
  endtask

  // Any status whose upper five bits differ from the code; often a timeout.
  function automatic logic [7:0] wrong_status(input logic [7:0] code);
    logic [7:0] s;
    if ($urandom_range(0, 3) == 0) return 8'h00;
    do s = 8'($urandom_range(0, 255)); while ((s & i2cseq_pkg::STATUS_MASK) == code);
    return s;
  endfunction

  // One full transaction: request, the engine events it expects (good codes
  // with random low bits), a wrong status at fail_at if that is >= 0, and the
  // closing stop event. Requests made while busy are mixed in at poke_pct.
  task automatic run_transaction(input bit as_read, input int count, input int fail_at,
                                 input logic [6:0] dev, input logic [7:0] regaddr,
                                 input logic [7:0] value, input int poke_pct);
    i2cseq_pkg::item_t it;
    logic [7:0]        codes[$];
    it = random_item(as_read ? i2cseq_pkg::CMD_READ : i2cseq_pkg::CMD_WRITE);
    it.device_address   = dev;
    it.register_address = regaddr;
    it.write_value      = value;
    if (as_read) it.read_count = 8'(count);
    send_item(it, 1'b1);
    codes = {i2cseq_pkg::ST_START, i2cseq_pkg::ST_SLA_W_ACK, i2cseq_pkg::ST_DATA_TX_ACK};
    if (as_read) begin
      codes.push_back(i2cseq_pkg::ST_RSTART);
      codes.push_back(i2cseq_pkg::ST_SLA_R_ACK);
      for (int i = 1; i < count; i++) codes.push_back(i2cseq_pkg::ST_DATA_RX_ACK);
      codes.push_back(i2cseq_pkg::ST_DATA_RX_NACK);
    end else begin
      codes.push_back(i2cseq_pkg::ST_DATA_TX_ACK);
    end
    foreach (codes[i]) begin
      if ($urandom_range(0, 99) < poke_pct)
        send_item(random_item(2'($urandom_range(0, 1))), 1'b1);
      if (i == fail_at) begin
        send_event(wrong_status(codes[i]));
        break;
      end
      send_event(codes[i] | 8'($urandom_range(0, 7)));
    end
    // stop event: status is not checked
    send_event(8'($urandom_range(0, 255)));
  endtask

  initial begin
    i2cseq_pkg::item_t it;
    bit    as_read;
    int    count;
    int    fail_at;
    int    pick;
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    command          <= i2cseq_pkg::CMD_EVENT;
    device_address   <= '0;
    register_address <= '0;
    write_value      <= '0;
    read_count       <= '0;
    bus_status       <= '0;
    bus_data         <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // engine event while idle, and the unused command: both ignored
    send_item(random_item(i2cseq_pkg::CMD_EVENT), 1'b0);
    send_item(random_item(CMD_UNUSED), 1'b0);
    // read of zero bytes is rejected
    it = random_item(i2cseq_pkg::CMD_READ);
    it.read_count = 8'd0;
    send_item(it, 1'b1);
    // write at the field maxima, a request while busy before every status event
    run_transaction(1'b0, 0, -1, 7'h7F, 8'hFF, 8'hFF, 100);
    // single-byte read at the minima, last byte comes back with a bad status
    run_transaction(1'b1, 1, 5, 7'h00, 8'h00, 8'h00, 0);
    // engine timeout on the very first event
    it = random_item(i2cseq_pkg::CMD_WRITE);
    send_item(it, 1'b1);
    send_event(8'h00);
    send_event(8'($urandom_range(0, 255)));

    // --- random ---
    // mostly well-formed transactions, some failing part way, plus noise
    while (useful_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        as_read = ($urandom_range(0, 99) < 60);
        count   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        fail_at = -1;
        if ($urandom_range(0, 3) == 0)
          fail_at = $urandom_range(0, as_read ? count + 4 : 3);
        run_transaction(as_read, count, fail_at, 7'($urandom_range(0, 127)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8);
      end else if (pick < 80) begin
        it = random_item(i2cseq_pkg::CMD_READ);
        it.read_count = 8'd0;
        send_item(it, 1'b1);
      end else if (pick < 90) begin
        send_item(random_item(i2cseq_pkg::CMD_EVENT), 1'b0);
      end else begin
        send_item(random_item(CMD_UNUSED), 1'b0);
      end
    end
    in_valid <= 1'b0;

    // drain, then wait for any stray result
    do @(negedge clk); while (results_outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/i2cseq_pkg.sv
rtl/i2cseq_fsm.sv
rtl/i2c_register_transaction_sequencer_top.sv
test/i2c_txn_checker.sv
test/tb_i2c_register_transaction_sequencer_top.sv
